FILE: sv/fop_pkg.sv
// Package for the four-op pipeline with store path: payload structs, stage types,
// command and operation codes, and default sizes.
// No dependencies; every other file of the block uses it.
package fop_pkg;

    localparam int unsigned NUM_REGS_DEF           = 16;
    localparam int unsigned MEM_WORDS_DEF          = 16;
    localparam int unsigned RESULT_QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] RESET_VALUE = 8'hFF;

    localparam logic [2:0] CMD_IDLE      = 3'd0;
    localparam logic [2:0] CMD_INSTR     = 3'd1;
    localparam logic [2:0] CMD_LOAD_REG  = 3'd2;
    localparam logic [2:0] CMD_LOAD_MEM  = 3'd3;
    localparam logic [2:0] CMD_READ_REG  = 3'd4;
    localparam logic [2:0] CMD_READ_MEM  = 3'd5;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SUB   = 2'd1;
    localparam logic [1:0] OP_MUL   = 2'd2;
    localparam logic [1:0] OP_STORE = 2'd3;

    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] op_code;
        logic [3:0] dest_reg;
        logic [3:0] src_a_reg;
        logic [3:0] src_b_reg;
        logic [7:0] offset_imm;
        logic [3:0] slot_index;
        logic [7:0] load_value;
    } instr_t;

    typedef struct packed {
        logic       reg_write_valid;
        logic [3:0] reg_write_index;
        logic [7:0] reg_write_value;
        logic       mem_write_valid;
        logic [3:0] mem_write_addr;
        logic [7:0] mem_write_value;
        logic       addr_fault;
        logic       queue_overflow;
        logic       pipeline_steady;
        logic       read_valid_bit;
        logic [7:0] read_value;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic [3:0] dest;
        logic [7:0] a;
        logic [7:0] b;
    } stage_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] dest;
        logic [7:0] a;
        logic [7:0] b;
    } mul_stage_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] src;
        logic [7:0] addr;
    } addr_stage_t;

    typedef struct packed {
        logic [3:0] dest;
        logic [7:0] value;
    } rq_entry_t;

endpackage

FILE: sv/four_op_pipeline_with_store_path_core.sv
// Top level of the four-op pipeline with store path: input register, one pass of
// pipeline logic, register file, data memory, result queue and result register.
// Depends on fop_pkg.
//
//   Channel   Valid          Stall          Payload              Direction
//   -------   ------------   ------------   ------------------   ---------
//   instr     instr_valid    instr_stall    instr  (instr_t)     into core
//   result    result_valid   result_stall   result (result_t)    out of core
//
// Every transaction passes through the input register and then the result register:
// its result is registered when the pipeline advances and stays offered until it is taken.
// One transaction is accepted per cycle while no stalled result holds the input register.
// Reset clears all valid bits, the stages and the queue count.
// A stalled result holds the input register, which then stalls the instr channel.
module four_op_pipeline_with_store_path_core #(
    parameter int unsigned NUM_REGS           = fop_pkg::NUM_REGS_DEF,
    parameter int unsigned MEM_WORDS          = fop_pkg::MEM_WORDS_DEF,
    parameter int unsigned RESULT_QUEUE_DEPTH = fop_pkg::RESULT_QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             instr_valid,
    output logic             instr_stall,
    input  fop_pkg::instr_t  instr,
    output logic             result_valid,
    input  logic             result_stall,
    output fop_pkg::result_t result
);

    localparam int unsigned RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int unsigned MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int unsigned CW  = $clog2(RESULT_QUEUE_DEPTH + 1);

    logic                   instr_valid_reg;
    fop_pkg::instr_t        instr_reg;
    logic                   result_valid_reg;
    fop_pkg::result_t       result_reg;
    fop_pkg::result_t       result_next;
    logic                   mem_sel_reg;
    logic                   mem_sel_next;
    logic [7:0]             mem_rd_reg;
    logic                   adv;

    logic [NUM_REGS-1:0][7:0] rf_values_reg;
    logic [NUM_REGS-1:0]      rf_valid_reg;
    logic [7:0]               mem_values_reg [MEM_WORDS];
    logic [MEM_WORDS-1:0]     mem_valid_reg;

    fop_pkg::stage_t        dec_reg, dec_next;
    fop_pkg::stage_t        arith_reg, arith_next;
    fop_pkg::stage_t        store_reg, store_next;
    fop_pkg::mul_stage_t    mul_reg, mul_next;
    fop_pkg::addr_stage_t   addr_reg, addr_next;
    fop_pkg::rq_entry_t     rq_reg [RESULT_QUEUE_DEPTH];
    fop_pkg::rq_entry_t     rq_next [RESULT_QUEUE_DEPTH];
    logic [CW-1:0]          rq_count_reg, rq_count_next;

    logic                   rf_we;
    logic [RIW-1:0]         rf_wa;
    logic [7:0]             rf_wd;
    logic                   mem_we;
    logic [MAW-1:0]         mem_wa;
    logic [7:0]             mem_wd;
    logic [MAW-1:0]         mem_ra;

    logic                   is_tick;
    logic                   wb_pop;
    logic                   wb_en;
    logic [3:0]             wb_idx;
    logic [7:0]             wb_val;
    logic [CW-1:0]          c1;
    logic [CW-1:0]          pos2;
    logic                   push1_req, push2_req, ok1, ok2;
    fop_pkg::rq_entry_t     e1, e2;
    logic [7:0]             st_val;
    logic [7:0]             st_addr_sum;
    logic [7:0]             slot_ext;
    logic [7:0]             src_ext;
    logic                   slot_reg_ok, slot_mem_ok;

    function automatic logic [7:0] rf_read(
        input logic [3:0]               idx,
        input logic [NUM_REGS-1:0][7:0] vals,
        input logic [NUM_REGS-1:0]      vld,
        input logic                     fwd_en,
        input logic [3:0]               fwd_idx,
        input logic [7:0]               fwd_val
    );
        logic [7:0]     ext;
        logic [RIW-1:0] ri;
        logic [7:0]     v;
        ext = 8'(idx);
        ri  = ext[RIW-1:0];
        v   = fop_pkg::RESET_VALUE;
        if (ext < 8'(NUM_REGS)) begin
            if (fwd_en && fwd_idx == idx)
                v = fwd_val;
            else if (vld[ri])
                v = vals[ri];
        end
        return v;
    endfunction

    assign adv          = instr_valid_reg && !(result_valid_reg && result_stall);
    assign instr_stall  = instr_valid_reg && !adv;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        result = result_reg;
        if (mem_sel_reg)
            result.read_value = result_reg.read_valid_bit ? mem_rd_reg : fop_pkg::RESET_VALUE;
    end

    always_comb
    begin
        result_next   = '0;
        mem_sel_next  = 1'b0;
        dec_next      = dec_reg;
        arith_next    = arith_reg;
        store_next    = store_reg;
        mul_next      = mul_reg;
        addr_next     = addr_reg;
        rq_count_next = rq_count_reg;
        rf_we         = 1'b0;
        rf_wa         = '0;
        rf_wd         = '0;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = '0;
        e1            = '0;
        e2            = '0;
        ok1           = 1'b0;
        ok2           = 1'b0;

        is_tick  = (instr_reg.cmd == fop_pkg::CMD_IDLE) || (instr_reg.cmd == fop_pkg::CMD_INSTR);
        slot_ext = 8'(instr_reg.slot_index);
        slot_reg_ok = slot_ext < 8'(NUM_REGS);
        slot_mem_ok = 9'(slot_ext) < 9'(MEM_WORDS);
        mem_ra   = slot_ext[MAW-1:0];

        wb_pop = is_tick && (rq_count_reg != '0);
        wb_idx = rq_reg[0].dest;
        wb_val = rq_reg[0].value;
        src_ext = 8'(wb_idx);
        wb_en  = wb_pop && (src_ext < 8'(NUM_REGS));

        c1        = rq_count_reg - CW'(wb_pop);
        push1_req = is_tick && mul_reg.valid;
        push2_req = is_tick && arith_reg.valid && (arith_reg.op != fop_pkg::OP_MUL);
        ok1       = push1_req && (c1 < CW'(RESULT_QUEUE_DEPTH));
        pos2      = c1 + CW'(ok1);
        ok2       = push2_req && (pos2 < CW'(RESULT_QUEUE_DEPTH));
        e1.dest   = mul_reg.dest;
        e1.value  = 8'(16'(mul_reg.a) * 16'(mul_reg.b));
        e2.dest   = arith_reg.dest;
        e2.value  = (arith_reg.op == fop_pkg::OP_ADD) ? (arith_reg.a + arith_reg.b)
                                                      : (arith_reg.a - arith_reg.b);

        for (int i = 0; i < int'(RESULT_QUEUE_DEPTH); i++) begin
            rq_next[i] = rq_reg[i];
            if (wb_pop && i < int'(RESULT_QUEUE_DEPTH) - 1)
                rq_next[i] = rq_reg[i + 1];
            if (ok1 && c1 == CW'(i))
                rq_next[i] = e1;
            if (ok2 && pos2 == CW'(i))
                rq_next[i] = e2;
        end

        st_val      = rf_read(addr_reg.src, rf_values_reg, rf_valid_reg, wb_en, wb_idx, wb_val);
        st_addr_sum = store_reg.a + store_reg.b;

        case (instr_reg.cmd)
            fop_pkg::CMD_IDLE, fop_pkg::CMD_INSTR:
            begin
                rq_count_next = pos2 + CW'(ok2);
                result_next.queue_overflow = (push1_req && !ok1) || (push2_req && !ok2);
                if (wb_en) begin
                    rf_we = 1'b1;
                    rf_wa = src_ext[RIW-1:0];
                    rf_wd = wb_val;
                    result_next.reg_write_valid = 1'b1;
                    result_next.reg_write_index = wb_idx;
                    result_next.reg_write_value = wb_val;
                end
                if (addr_reg.valid) begin
                    if (9'(addr_reg.addr) < 9'(MEM_WORDS)) begin
                        mem_we = 1'b1;
                        mem_wa = addr_reg.addr[MAW-1:0];
                        mem_wd = st_val;
                        result_next.mem_write_valid = 1'b1;
                        result_next.mem_write_addr  = addr_reg.addr[3:0];
                        result_next.mem_write_value = st_val;
                    end else begin
                        result_next.addr_fault = 1'b1;
                    end
                end

                mul_next.valid = arith_reg.valid && (arith_reg.op == fop_pkg::OP_MUL);
                mul_next.dest  = arith_reg.dest;
                mul_next.a     = arith_reg.a;
                mul_next.b     = arith_reg.b;

                addr_next.valid = store_reg.valid;
                addr_next.src   = store_reg.dest;
                addr_next.addr  = st_addr_sum;

                arith_next       = dec_reg;
                arith_next.valid = dec_reg.valid && (dec_reg.op != fop_pkg::OP_STORE);
                store_next       = dec_reg;
                store_next.valid = dec_reg.valid && (dec_reg.op == fop_pkg::OP_STORE);

                dec_next.valid = (instr_reg.cmd == fop_pkg::CMD_INSTR);
                dec_next.op    = instr_reg.op_code;
                dec_next.dest  = instr_reg.dest_reg;
                dec_next.a     = rf_read(instr_reg.src_a_reg, rf_values_reg, rf_valid_reg,
                                         wb_en, wb_idx, wb_val);
                if (instr_reg.op_code == fop_pkg::OP_STORE)
                    dec_next.b = instr_reg.offset_imm;
                else
                    dec_next.b = rf_read(instr_reg.src_b_reg, rf_values_reg, rf_valid_reg,
                                         wb_en, wb_idx, wb_val);
            end
            fop_pkg::CMD_LOAD_REG:
            begin
                if (slot_reg_ok) begin
                    rf_we = 1'b1;
                    rf_wa = slot_ext[RIW-1:0];
                    rf_wd = instr_reg.load_value;
                end
            end
            fop_pkg::CMD_LOAD_MEM:
            begin
                if (slot_mem_ok) begin
                    mem_we = 1'b1;
                    mem_wa = slot_ext[MAW-1:0];
                    mem_wd = instr_reg.load_value;
                end
            end
            fop_pkg::CMD_READ_REG:
            begin
                if (slot_reg_ok) begin
                    result_next.read_valid_bit = rf_valid_reg[slot_ext[RIW-1:0]];
                    result_next.read_value     = rf_read(instr_reg.slot_index, rf_values_reg,
                                                         rf_valid_reg, 1'b0, '0, '0);
                end
            end
            fop_pkg::CMD_READ_MEM:
            begin
                if (slot_mem_ok) begin
                    result_next.read_valid_bit = mem_valid_reg[slot_ext[MAW-1:0]];
                    mem_sel_next               = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        result_next.pipeline_steady = !dec_next.valid && !arith_next.valid && !store_next.valid
                                      && !mul_next.valid && !addr_next.valid
                                      && (rq_count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            instr_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            mem_sel_reg      <= 1'b0;
            rf_valid_reg     <= '0;
            mem_valid_reg    <= '0;
            dec_reg          <= '0;
            arith_reg        <= '0;
            store_reg        <= '0;
            mul_reg          <= '0;
            addr_reg         <= '0;
            rq_count_reg     <= '0;
        end else begin
            if (instr_valid && !instr_stall)
                instr_valid_reg <= 1'b1;
            else if (adv)
                instr_valid_reg <= 1'b0;

            if (adv)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            if (adv) begin
                mem_sel_reg  <= mem_sel_next;
                dec_reg      <= dec_next;
                arith_reg    <= arith_next;
                store_reg    <= store_next;
                mul_reg      <= mul_next;
                addr_reg     <= addr_next;
                rq_count_reg <= rq_count_next;
                if (rf_we)
                    rf_valid_reg[rf_wa] <= 1'b1;
                if (mem_we)
                    mem_valid_reg[mem_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr_valid && !instr_stall)
            instr_reg <= instr;
        if (adv) begin
            result_reg <= result_next;
            rq_reg     <= rq_next;
            if (rf_we)
                rf_values_reg[rf_wa] <= rf_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            if (mem_we)
                mem_values_reg[mem_wa] <= mem_wd;
            mem_rd_reg <= mem_values_reg[mem_ra];
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_count_reg <= CW'(RESULT_QUEUE_DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_one_route: assert property (@(posedge clk) disable iff (!rst_n)
        !(arith_reg.valid && store_reg.valid))
        else $error("Decode routed one instruction to both stages.");

    a_mul_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && arith_reg.valid && arith_reg.op == fop_pkg::OP_MUL && is_tick) |=> mul_reg.valid)
        else $error("A multiply did not reach its second stage.");

    a_no_tick_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !is_tick) |=> !(result_reg.reg_write_valid || result_reg.mem_write_valid
                                || result_reg.addr_fault || result_reg.queue_overflow))
        else $error("A transaction without a tick reported pipeline activity.");

    a_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.mem_write_valid && result_reg.addr_fault))
        else $error("A store both wrote memory and faulted.");

endmodule

FILE: test/four_op_pipeline_with_store_path_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for four_op_pipeline_with_store_path_core: a pipeline model predicts
// every result transaction, which is compared field by field as it arrives.
// Depends on fop_pkg and the core RTL.
module four_op_pipeline_with_store_path_core_tb;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 100;

    logic             clk;
    logic             rst_n;
    logic             instr_valid;
    logic             instr_stall;
    fop_pkg::instr_t  instr;
    logic             result_valid;
    logic             result_stall;
    fop_pkg::result_t result;

    logic       reg_val [fop_pkg::NUM_REGS_DEF];
    logic [7:0] reg_data [fop_pkg::NUM_REGS_DEF];
    logic       mem_val [fop_pkg::MEM_WORDS_DEF];
    logic [7:0] mem_data [fop_pkg::MEM_WORDS_DEF];
    fop_pkg::stage_t      decode_s;
    fop_pkg::stage_t      alu_s;
    fop_pkg::stage_t      store_s;
    fop_pkg::mul_stage_t  mul_s;
    fop_pkg::addr_stage_t addr_s;
    fop_pkg::rq_entry_t   writeback_q [$];

    fop_pkg::result_t pipe_outputs_q [$];
    int      mismatches;
    int      hold_request;
    bit      sender_idle;
    bit      receiver_idle;

    four_op_pipeline_with_store_path_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr        (instr),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic clear_model();
        for (int i = 0; i < fop_pkg::NUM_REGS_DEF; i++)
        begin
            reg_data[i] = fop_pkg::RESET_VALUE;
            reg_val[i]  = 1'b0;
        end
        for (int i = 0; i < fop_pkg::MEM_WORDS_DEF; i++)
        begin
            mem_data[i] = fop_pkg::RESET_VALUE;
            mem_val[i]  = 1'b0;
        end
        decode_s = '0;
        alu_s    = '0;
        store_s  = '0;
        mul_s    = '0;
        addr_s   = '0;
        writeback_q.delete();
    endtask

    task automatic push_writeback(input logic [3:0] dest, input logic [7:0] value,
                                  inout logic overflow);
        fop_pkg::rq_entry_t e;
        if (writeback_q.size() >= fop_pkg::RESULT_QUEUE_DEPTH_DEF)
        begin
            overflow = 1'b1;
        end
        else
        begin
            e.dest  = dest;
            e.value = value;
            writeback_q.insert(writeback_q.size(), e);
        end
    endtask

    task automatic run_pipeline_model(input fop_pkg::instr_t t, output fop_pkg::result_t r);
        fop_pkg::rq_entry_t head;
        logic [7:0]         v;
        logic               overflow;
        r = '0;
        overflow = 1'b0;
        case (t.cmd)
            fop_pkg::CMD_IDLE, fop_pkg::CMD_INSTR:
            begin
                if (writeback_q.size() != 0)
                begin
                    head = writeback_q[0];
                    writeback_q.delete(0);
                    reg_data[head.dest] = head.value;
                    reg_val[head.dest]  = 1'b1;
                    r.reg_write_valid = 1'b1;
                    r.reg_write_index = head.dest;
                    r.reg_write_value = head.value;
                end
                if (mul_s.valid)
                begin
                    v = mul_s.a * mul_s.b;
                    push_writeback(mul_s.dest, v, overflow);
                end
                mul_s.valid = 1'b0;
                if (alu_s.valid)
                begin
                    if (alu_s.op == fop_pkg::OP_MUL)
                    begin
                        mul_s.valid = 1'b1;
                        mul_s.dest  = alu_s.dest;
                        mul_s.a     = alu_s.a;
                        mul_s.b     = alu_s.b;
                    end
                    else if (alu_s.op == fop_pkg::OP_ADD)
                    begin
                        v = alu_s.a + alu_s.b;
                        push_writeback(alu_s.dest, v, overflow);
                    end
                    else
                    begin
                        v = alu_s.a - alu_s.b;
                        push_writeback(alu_s.dest, v, overflow);
                    end
                end
                if (addr_s.valid)
                begin
                    if (addr_s.addr < fop_pkg::MEM_WORDS_DEF)
                    begin
                        v = reg_data[addr_s.src];
                        mem_data[addr_s.addr[3:0]] = v;
                        mem_val[addr_s.addr[3:0]]  = 1'b1;
                        r.mem_write_valid = 1'b1;
                        r.mem_write_addr  = addr_s.addr[3:0];
                        r.mem_write_value = v;
                    end
                    else
                    begin
                        r.addr_fault = 1'b1;
                    end
                end
                addr_s.valid = 1'b0;
                if (store_s.valid)
                begin
                    v = store_s.a + store_s.b;
                    addr_s.valid = 1'b1;
                    addr_s.src   = store_s.dest;
                    addr_s.addr  = v;
                end
                alu_s.valid   = 1'b0;
                store_s.valid = 1'b0;
                if (decode_s.valid)
                begin
                    if (decode_s.op == fop_pkg::OP_STORE)
                        store_s = decode_s;
                    else
                        alu_s = decode_s;
                end
                decode_s.valid = 1'b0;
                if (t.cmd == fop_pkg::CMD_INSTR)
                begin
                    decode_s.valid = 1'b1;
                    decode_s.op    = t.op_code;
                    decode_s.dest  = t.dest_reg;
                    decode_s.a     = reg_data[t.src_a_reg];
                    decode_s.b     = (t.op_code == fop_pkg::OP_STORE) ? t.offset_imm
                                                                      : reg_data[t.src_b_reg];
                end
                r.queue_overflow = overflow;
            end
            fop_pkg::CMD_LOAD_REG:
            begin
                reg_data[t.slot_index] = t.load_value;
                reg_val[t.slot_index]  = 1'b1;
            end
            fop_pkg::CMD_LOAD_MEM:
            begin
                mem_data[t.slot_index] = t.load_value;
                mem_val[t.slot_index]  = 1'b1;
            end
            fop_pkg::CMD_READ_REG:
            begin
                r.read_valid_bit = reg_val[t.slot_index];
                r.read_value     = reg_data[t.slot_index];
            end
            fop_pkg::CMD_READ_MEM:
            begin
                r.read_valid_bit = mem_val[t.slot_index];
                r.read_value     = mem_data[t.slot_index];
            end
            default:
            begin
            end
        endcase
        r.pipeline_steady = !(decode_s.valid || alu_s.valid || store_s.valid ||
                              mul_s.valid || addr_s.valid) && (writeback_q.size() == 0);
    endtask

    function automatic fop_pkg::instr_t op_item(input logic [1:0] op, input logic [3:0] dest,
                                                input logic [3:0] a, input logic [3:0] b,
                                                input logic [7:0] offset);
        fop_pkg::instr_t t;
        t = '0;
        t.cmd        = fop_pkg::CMD_INSTR;
        t.op_code    = op;
        t.dest_reg   = dest;
        t.src_a_reg  = a;
        t.src_b_reg  = b;
        t.offset_imm = offset;
        return t;
    endfunction

    function automatic fop_pkg::instr_t cmd_item(input logic [2:0] cmd, input logic [3:0] slot,
                                                 input logic [7:0] value);
        fop_pkg::instr_t t;
        t = '0;
        t.cmd        = cmd;
        t.slot_index = slot;
        t.load_value = value;
        return t;
    endfunction

    function automatic fop_pkg::instr_t random_item();
        fop_pkg::instr_t t;
        int              pick;
        logic [7:0]      target;
        t.op_code    = 2'($urandom_range(0, 3));
        t.dest_reg   = 4'($urandom_range(0, 15));
        t.src_a_reg  = 4'($urandom_range(0, 15));
        t.src_b_reg  = 4'($urandom_range(0, 15));
        t.offset_imm = 8'($urandom_range(0, 255));
        t.slot_index = 4'($urandom_range(0, 15));
        t.load_value = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15))
                                                   : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            t.cmd = fop_pkg::CMD_IDLE;
        else if (pick < 65)
            t.cmd = fop_pkg::CMD_INSTR;
        else if (pick < 73)
            t.cmd = fop_pkg::CMD_LOAD_REG;
        else if (pick < 80)
            t.cmd = fop_pkg::CMD_LOAD_MEM;
        else if (pick < 88)
            t.cmd = fop_pkg::CMD_READ_REG;
        else if (pick < 96)
            t.cmd = fop_pkg::CMD_READ_MEM;
        else
            t.cmd = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        if (t.cmd == fop_pkg::CMD_INSTR && t.op_code == fop_pkg::OP_STORE &&
            $urandom_range(0, 2) != 0)
        begin
            target = 8'($urandom_range(0, fop_pkg::MEM_WORDS_DEF - 1));
            t.offset_imm = target - reg_data[t.src_a_reg];
        end
        return t;
    endfunction

    task automatic send_item(input fop_pkg::instr_t t);
        int               gap;
        fop_pkg::result_t r;
        gap = sender_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            instr_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr       <= t;
        instr_valid <= 1'b1;
        do @(posedge clk); while (instr_stall);
        run_pipeline_model(t, r);
        pipe_outputs_q.insert(pipe_outputs_q.size(), r);
    endtask

    task automatic wait_for_results();
        instr_valid <= 1'b0;
        do @(posedge clk); while (pipe_outputs_q.size() != 0);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    initial
    begin : result_check
        fop_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
            begin
                if (pipe_outputs_q.size() == 0)
                begin
                    report_mismatch("result transaction with nothing pending");
                end
                else
                begin
                    want = pipe_outputs_q[0];
                    pipe_outputs_q.delete(0);
                    check_field("reg_write_valid", 8'(result.reg_write_valid),
                                8'(want.reg_write_valid));
                    check_field("reg_write_index", 8'(result.reg_write_index),
                                8'(want.reg_write_index));
                    check_field("reg_write_value", result.reg_write_value,
                                want.reg_write_value);
                    check_field("mem_write_valid", 8'(result.mem_write_valid),
                                8'(want.mem_write_valid));
                    check_field("mem_write_addr", 8'(result.mem_write_addr),
                                8'(want.mem_write_addr));
                    check_field("mem_write_value", result.mem_write_value,
                                want.mem_write_value);
                    check_field("addr_fault", 8'(result.addr_fault), 8'(want.addr_fault));
                    check_field("queue_overflow", 8'(result.queue_overflow),
                                8'(want.queue_overflow));
                    check_field("pipeline_steady", 8'(result.pipeline_steady),
                                8'(want.pipeline_steady));
                    check_field("read_valid_bit", 8'(result.read_valid_bit),
                                8'(want.read_valid_bit));
                    check_field("read_value", result.read_value, want.read_value);
                end
            end
        end
    end

    initial
    begin : result_sink
        int hold;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request != 0)
            begin
                hold = hold_request;
                hold_request = 0;
            end
            else
            begin
                hold = receiver_idle ? $urandom_range(0, 5) : 0;
            end
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (result_valid !== 1'b1);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((instr_valid === 1'b1 && instr_stall === 1'b0) ||
                (result_valid === 1'b1 && result_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Registers and memory read as 0xFF with a clear valid mark before any write.
    task automatic test_power_on_state();
        send_item(cmd_item(fop_pkg::CMD_READ_REG, 4'd0, 8'h00));
        send_item(cmd_item(fop_pkg::CMD_READ_REG, 4'd15, 8'hFF));
        send_item(cmd_item(fop_pkg::CMD_READ_MEM, 4'd0, 8'h00));
        send_item(cmd_item(fop_pkg::CMD_READ_MEM, 4'd15, 8'hFF));
    endtask

    task automatic test_unused_commands();
        send_item(cmd_item(CMD_UNUSED_LO, 4'd15, 8'hFF));
        send_item(cmd_item(CMD_UNUSED_HI, 4'd0, 8'h00));
    endtask

    task automatic test_preload_extremes();
        send_item(cmd_item(fop_pkg::CMD_LOAD_REG, 4'd0, 8'h00));
        send_item(cmd_item(fop_pkg::CMD_LOAD_REG, 4'd15, 8'hFF));
        send_item(cmd_item(fop_pkg::CMD_LOAD_REG, 4'd1, 8'h80));
        send_item(cmd_item(fop_pkg::CMD_LOAD_MEM, 4'd0, 8'h00));
    endtask

    // A multiply followed directly by an add puts two results into the queue in one tick.
    task automatic test_arith_ops();
        send_item(op_item(fop_pkg::OP_ADD, 4'd2, 4'd15, 4'd1, 8'h00));
        send_item(op_item(fop_pkg::OP_SUB, 4'd3, 4'd0, 4'd15, 8'hFF));
        send_item(op_item(fop_pkg::OP_MUL, 4'd4, 4'd15, 4'd15, 8'h00));
        send_item(op_item(fop_pkg::OP_MUL, 4'd5, 4'd1, 4'd1, 8'h00));
        send_item(op_item(fop_pkg::OP_ADD, 4'd6, 4'd1, 4'd15, 8'h00));
        repeat (3) send_item(cmd_item(fop_pkg::CMD_IDLE, 4'd0, 8'h00));
    endtask

    // Covers a source register never written, an address that wraps past 255,
    // and an address beyond the data memory.
    task automatic test_store_path();
        send_item(op_item(fop_pkg::OP_STORE, 4'd7, 4'd0, 4'd0, 8'd15));
        send_item(op_item(fop_pkg::OP_STORE, 4'd2, 4'd15, 4'd15, 8'h01));
        send_item(op_item(fop_pkg::OP_STORE, 4'd3, 4'd0, 4'd0, 8'hFF));
        repeat (3) send_item(cmd_item(fop_pkg::CMD_IDLE, 4'd0, 8'h00));
        send_item(cmd_item(fop_pkg::CMD_READ_MEM, 4'd15, 8'h00));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
        begin
            send_item(random_item());
            if ($urandom_range(0, 99) == 0)
                wait_for_results();
        end
    endtask

    // The receiver holds off long enough that the core fills and stalls its input.
    task automatic test_receiver_hold();
        sender_idle  = 1'b0;
        hold_request = 60;
        repeat (24) send_item(random_item());
    endtask

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        instr_valid   <= 1'b0;
        instr         <= '0;
        mismatches    = 0;
        hold_request  = 0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        clear_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_state();
        test_unused_commands();
        test_preload_extremes();
        test_arith_ops();
        test_store_path();
        wait_for_results();

        test_random_traffic(300);
        wait_for_results();

        test_receiver_hold();
        wait_for_results();

        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random_traffic(200);
        wait_for_results();

        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        test_random_traffic(150);
        wait_for_results();

        sender_idle = 1'b0;
        test_random_traffic(150);
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
